// ----- sv/sed_pkg.sv -----
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types and constants of the Sobel edge detector.
// ----------------------------------------------------------------------------
`default_nettype none

package sed_pkg;

  localparam int MAX_LINE_WIDTH   = 1024;
  localparam int MAX_FRAME_HEIGHT = 1024;
  localparam int LINE_AW          = $clog2(MAX_LINE_WIDTH);

  localparam int PIX_W  = 8;
  localparam int CFG_W  = 11;
  localparam int IDX_W  = 2;
  localparam int SUM_W  = 21;   // gx^2 + gy^2 stays below 2^21
  localparam int SQRT_W = 11;   // floor sqrt of that fits 11 bits

  localparam logic [IDX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [CFG_W-1:0] THRESHOLD_RST = 11'd100;
  localparam logic [CFG_W-1:0] WIDTH_RST     = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST    = 11'd480;
  localparam logic [CFG_W-1:0] DIM_MIN       = 11'd3;
  localparam logic [CFG_W-1:0] WIDTH_MAX     = CFG_W'(MAX_LINE_WIDTH);
  localparam logic [CFG_W-1:0] HEIGHT_MAX    = CFG_W'(MAX_FRAME_HEIGHT);

  localparam logic [SUM_W-1:0] SQRT_BIT_INIT = SUM_W'(1) << (SUM_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_SQRT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;       // take the pixel, set position and gray
    logic rd;         // read both line stores at the column
    logic calc;       // gradients, store update, window shift, advance counters
    logic sqrt_step;  // one root iteration
    logic out_load;   // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic interior;   // current pixel closes a full window
    logic sqrt_last;  // root iteration in progress is the last one
    logic out_free;   // output register can take a result
  } status_t;

endpackage

`default_nettype wire

// ----- sv/sed_ram.sv -----
// ----------------------------------------------------------------------------
// sed_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/sed_ctrl.sv -----
// ----------------------------------------------------------------------------
// sed_ctrl
// Sequencer: accept, line store read, gradient, then root iterations and hand-off for interior pixels only.
// ----------------------------------------------------------------------------
`default_nettype none

module sed_ctrl import sed_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_READ;
      end
      S_READ: state_next = S_CALC;
      S_CALC: begin
        state_next = status.interior ? S_SQRT : S_IDLE;
      end
      S_SQRT: begin
        if (status.sqrt_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_READ: cmd.rd = 1'b1;
      S_CALC: cmd.calc = 1'b1;
      S_SQRT: cmd.sqrt_step = 1'b1;
      S_DONE: cmd.out_load = status.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/sed_datapath.sv -----
// ----------------------------------------------------------------------------
// sed_datapath
// Gray conversion, line stores, window, gradients, iterative root, output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module sed_datapath import sed_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic [PIX_W-1:0] red,
  input  wire logic [PIX_W-1:0] green,
  input  wire logic [PIX_W-1:0] blue,
  input  wire cmd_t             cmd,
  output status_t               status,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [PIX_W-1:0] edge_value,
  output logic                  frame_end
);

  logic [CFG_W-1:0] threshold, frame_width, frame_height;
  logic [CFG_W-1:0] w_eff, h_eff;
  logic [CFG_W-1:0] column_count, row_count;
  logic [CFG_W-1:0] col, row;
  logic [CFG_W-1:0] col_in, row_in, row_wrap;
  logic [PIX_W-1:0] gray;
  logic [15:0]      gray_sum;
  logic [PIX_W-1:0] win [6];
  logic [PIX_W-1:0] top, mid;
  logic signed [11:0] gx, gy;
  logic [19:0]      gx_sq, gy_sq;
  logic             interior, last_pix;
  logic [SUM_W-1:0] sq_rem, sq_res, sq_bit, sq_trial;
  logic [CFG_W-1:0] col_inc, row_inc;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RST;
      frame_width  <= WIDTH_RST;
      frame_height <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD:    threshold    <= cfg_data;
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = (frame_width < DIM_MIN) ? DIM_MIN :
                 (frame_width > WIDTH_MAX) ? WIDTH_MAX : frame_width;
  assign h_eff = (frame_height < DIM_MIN) ? DIM_MIN :
                 (frame_height > HEIGHT_MAX) ? HEIGHT_MAX : frame_height;

  // position of the incoming pixel after a geometry change
  always_comb begin
    col_in   = column_count;
    row_wrap = row_count;
    if (column_count >= w_eff) begin
      col_in   = '0;
      row_wrap = row_count + 1'b1;
    end
    row_in = (row_wrap >= h_eff) ? '0 : row_wrap;
  end

  assign gray_sum = (16'(red) * 16'd77) + (16'(green) * 16'd150) + (16'(blue) * 16'd29);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gray <= gray_sum[15:8];
      col  <= col_in;
      row  <= row_in;
    end
  end

  sed_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE_WIDTH)) u_upper (
    .clk   (clk),
    .we    (cmd.calc),
    .waddr (col[LINE_AW-1:0]),
    .wdata (mid),
    .re    (cmd.rd),
    .raddr (col[LINE_AW-1:0]),
    .rdata (top)
  );

  sed_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE_WIDTH)) u_middle (
    .clk   (clk),
    .we    (cmd.calc),
    .waddr (col[LINE_AW-1:0]),
    .wdata (gray),
    .re    (cmd.rd),
    .raddr (col[LINE_AW-1:0]),
    .rdata (mid)
  );

  // gradients over the window
  always_comb begin
    gx = (12'(top) + 12'({mid, 1'b0}) + 12'(gray))
       - (12'(win[0]) + 12'({win[1], 1'b0}) + 12'(win[2]));
    gy = (12'(win[2]) + 12'({win[5], 1'b0}) + 12'(gray))
       - (12'(win[0]) + 12'({win[3], 1'b0}) + 12'(top));
  end

  // widen before squaring so the full product is kept
  assign gx_sq    = 20'(gx) * 20'(gx);
  assign gy_sq    = 20'(gy) * 20'(gy);
  assign interior = (row >= 11'd2) && (col >= 11'd2);
  assign last_pix = (row == h_eff - 1'b1) && (col == w_eff - 1'b1);

  assign col_inc = col + 1'b1;
  assign row_inc = row + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      for (int i = 0; i < 6; i++) win[i] <= '0;
    end else if (cmd.calc) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= gray;
      if (col_inc >= w_eff) begin
        column_count <= '0;
        row_count    <= (row_inc >= h_eff) ? '0 : row_inc;
      end else begin
        column_count <= col_inc;
        row_count    <= row;
      end
    end
  end

  // digit-by-digit square root, one result bit per cycle
  assign sq_trial = sq_res + sq_bit;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      sq_rem   <= SUM_W'(gx_sq) + SUM_W'(gy_sq);
      sq_res   <= '0;
      sq_bit   <= SQRT_BIT_INIT;
    end else if (cmd.sqrt_step) begin
      if (sq_rem >= sq_trial) begin
        sq_rem <= sq_rem - sq_trial;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  logic last_q;

  always_ff @(posedge clk) begin
    if (cmd.calc) last_q <= last_pix;
  end

  assign status.interior  = interior;
  assign status.sqrt_last = sq_bit[0];
  assign status.out_free  = !out_valid || out_ready;

  // output register
  logic [SQRT_W-1:0] mag;
  assign mag = sq_res[SQRT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      edge_value <= (mag > threshold || mag > 11'd255) ? 8'hFF : mag[PIX_W-1:0];
      frame_end  <= last_q;
    end
  end

endmodule

`default_nettype wire

// ----- sv/sobel_edge_detector.sv -----
// ----------------------------------------------------------------------------
// sobel_edge_detector
// Streaming 3x3 Sobel edge detector on RGB pixels in raster order.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  ------------------------------
//  input    in_valid / in_ready  red, green, blue (8 bits each)
//  output   out_valid/out_ready  edge_value (8), frame_end (1)
//  config   cfg_we               cfg_index (2), cfg_data (11)
//
//  One pixel is in work at a time. A border pixel passes accept, line
//  store read and gradient only; an interior pixel adds 11 root
//  iterations (one result bit each), then hand-off to the output register.
//  The output register lets the next pixel be taken while a result waits.
//  Reset is synchronous; line stores are not cleared and need no sweep.
//  A stalled output holds the sequencer in its hand-off state only while
//  the output register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_detector import sed_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  // configuration writes: threshold, frame_width, frame_height
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  // pixel transaction in
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [PIX_W-1:0] red,
  input  wire logic [PIX_W-1:0] green,
  input  wire logic [PIX_W-1:0] blue,
  // edge transaction out
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [PIX_W-1:0] edge_value,
  output logic                  frame_end
);

  cmd_t    cmd;
  status_t status;

  // sequencer: advance one step per cycle, wait in idle for a pixel, hold in hand-off on a full output
  sed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: gray, line stores, window, gradient, root, output register
  sed_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .edge_value (edge_value),
    .frame_end  (frame_end)
  );

endmodule

`default_nettype wire
